// ===== design/blr_pkg.sv =====
// ----------------------------------------------------------------------------
// blr_pkg
// Shared widths, register addresses and helpers for the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

	localparam int COORD_BITS = 16;
	localparam int REG_W      = 13;
	localparam int ADDR_W     = 24;
	localparam int COLOR_W    = 32;
	localparam int DELTA_W    = COORD_BITS + 1;
	localparam int ERR_W      = COORD_BITS + 3;
	localparam int CMP_W      = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [REG_W-1:0] WIDTH_RESET  = REG_W'(640);
	localparam logic [REG_W-1:0] HEIGHT_RESET = REG_W'(480);

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DELTA_W-1:0]    delta_t;
	typedef logic signed [ERR_W-1:0]      err_t;

	// low ADDR_W bits of a coordinate, zero-extended where narrower
	function automatic logic [ADDR_W-1:0] coord_to_addr(input logic [COORD_BITS-1:0] v);
		logic [COORD_BITS+ADDR_W-1:0] t;
		t = {{ADDR_W{1'b0}}, v};
		return t[ADDR_W-1:0];
	endfunction

	// zero-extend a non-negative coordinate to the compare width
	function automatic logic [CMP_W-1:0] coord_to_cmp(input logic [COORD_BITS-1:0] v);
		logic [COORD_BITS+CMP_W-1:0] t;
		t = {{CMP_W{1'b0}}, v};
		return t[CMP_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/bresenham_line_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// Integer Bresenham line rasterizer: start loads a line, each step on an active line emits
// one pixel with clip flag, linear address and last flag.
// ----------------------------------------------------------------------------
// Pipeline: two register stages; stage 1 captures a step's pixel, stage 2 drives the output.
// Throughput: one transaction per cycle unless out_ready back-pressure stalls it; the line state
// updates at input accept, the address multiply-add sits in the second stage.
// Reset: arst_n clears line state (no line active), pipeline valids, and sets
// surface_width to 640 and surface_height to 480.
`default_nettype none

module bresenham_line_rasterizer_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	// input channel
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                command,
	input  wire  signed [blr_pkg::COORD_BITS-1:0] start_x,
	input  wire  signed [blr_pkg::COORD_BITS-1:0] start_y,
	input  wire  signed [blr_pkg::COORD_BITS-1:0] end_x,
	input  wire  signed [blr_pkg::COORD_BITS-1:0] end_y,
	input  wire         [blr_pkg::COLOR_W-1:0]    line_color,
	// output channel
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic signed [blr_pkg::COORD_BITS-1:0] pixel_x,
	output logic signed [blr_pkg::COORD_BITS-1:0] pixel_y,
	output logic        [blr_pkg::ADDR_W-1:0]     pixel_address,
	output logic        [blr_pkg::COLOR_W-1:0]    pixel_color,
	output logic                               inside_res,
	output logic                               last,
	// configuration
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire         [blr_pkg::PADDR_W-1:0]    paddr,
	input  wire         [blr_pkg::PDATA_W-1:0]    pwdata,
	output logic        [blr_pkg::PDATA_W-1:0]    prdata,
	output logic                               pready
);
	import blr_pkg::*;

	logic [REG_W-1:0] width_q;
	logic [REG_W-1:0] height_q;

	coord_t                cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	delta_t                delta_x_q, delta_y_q;
	err_t                  err_q;
	logic                  step_x_neg_q, step_y_neg_q;
	logic [COLOR_W-1:0]    color_q;
	logic                  active_q;

	logic                  valid_s1;
	coord_t                x_s1, y_s1;
	logic [COLOR_W-1:0]    color_s1;
	logic                  inside_s1, last_s1;

	logic                  adv_s2, in_fire, cfg_wr;
	reg_idx_t              reg_sel;

	// start decode
	delta_t                sx0, sy0, sx1, sy1, dx_n, dy_n;
	err_t                  err_start;
	// step decode
	logic                  inside_now, last_now, mv_x, mv_y;
	err_t                  dx_e, dy_e, err_next;
	coord_t                x_next, y_next;
	// address
	logic [ADDR_W-1:0]     addr_calc;

	assign pready   = 1'b1;
	assign adv_s2   = !out_valid || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign in_fire  = in_valid && in_ready;
	assign reg_sel  = reg_idx_t'(paddr[2]);
	assign cfg_wr   = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_sel)
			REG_WIDTH:  prdata = {{(PDATA_W-REG_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(PDATA_W-REG_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_WIDTH:  width_q  <= pwdata[REG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[REG_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		sx0  = delta_t'(start_x);
		sy0  = delta_t'(start_y);
		sx1  = delta_t'(end_x);
		sy1  = delta_t'(end_y);
		dx_n = (sx1 >= sx0) ? (sx1 - sx0) : (sx0 - sx1);
		dy_n = (sy1 >= sy0) ? (sy1 - sy0) : (sy0 - sy1);
		if (dx_n > dy_n)
			err_start = err_t'(dx_n >>> 1);
		else
			err_start = -err_t'(dy_n >>> 1);
	end

	always_comb begin
		inside_now = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1]
		             && (coord_to_cmp(cur_x_q) < CMP_W'(width_q))
		             && (coord_to_cmp(cur_y_q) < CMP_W'(height_q));
		last_now   = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
		dx_e       = err_t'(delta_x_q);
		dy_e       = err_t'(delta_y_q);
		mv_x       = err_q > -dx_e;
		mv_y       = err_q < dy_e;
		err_next   = err_q - (mv_x ? dy_e : '0) + (mv_y ? dx_e : '0);
		x_next     = mv_x ? (step_x_neg_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1))
		                  : cur_x_q;
		y_next     = mv_y ? (step_y_neg_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1))
		                  : cur_y_q;
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			goal_x_q     <= '0;
			goal_y_q     <= '0;
			delta_x_q    <= '0;
			delta_y_q    <= '0;
			err_q        <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			color_q      <= '0;
			active_q     <= 1'b0;
		end else if (in_fire) begin
			if (cmd_t'(command) == CMD_START) begin
				cur_x_q      <= start_x;
				cur_y_q      <= start_y;
				goal_x_q     <= end_x;
				goal_y_q     <= end_y;
				delta_x_q    <= dx_n;
				delta_y_q    <= dy_n;
				err_q        <= err_start;
				step_x_neg_q <= !(start_x < end_x);
				step_y_neg_q <= !(start_y < end_y);
				color_q      <= line_color;
				active_q     <= 1'b1;
			end else if (active_q) begin
				if (last_now) begin
					active_q <= 1'b0;
				end else begin
					cur_x_q <= x_next;
					cur_y_q <= y_next;
					err_q   <= err_next;
				end
			end
		end
	end

	// stage 1: pixel captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_fire && (cmd_t'(command) == CMD_STEP) && active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_s1      <= cur_x_q;
			y_s1      <= cur_y_q;
			color_s1  <= color_q;
			inside_s1 <= inside_now;
			last_s1   <= last_now;
		end
	end

	// stage 2: address and output register
	assign addr_calc = coord_to_addr(y_s1) * {{(ADDR_W-REG_W){1'b0}}, width_q}
	                   + coord_to_addr(x_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_x       <= x_s1;
			pixel_y       <= y_s1;
			pixel_address <= inside_s1 ? addr_calc : '0;
			pixel_color   <= color_s1;
			inside_res    <= inside_s1;
			last          <= last_s1;
		end
	end

endmodule

`default_nettype wire

// ===== sim/blr_pixel_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blr_pixel_checker
// Follows surface register writes and line transactions, predicts each pixel
// the rasterizer must emit and compares it field by field on the output side.
// ----------------------------------------------------------------------------

module blr_pixel_checker (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	input  wire                                   in_ready,
	input  wire                                   command,
	input  wire  signed [blr_pkg::COORD_BITS-1:0] start_x,
	input  wire  signed [blr_pkg::COORD_BITS-1:0] start_y,
	input  wire  signed [blr_pkg::COORD_BITS-1:0] end_x,
	input  wire  signed [blr_pkg::COORD_BITS-1:0] end_y,
	input  wire         [blr_pkg::COLOR_W-1:0]    line_color,
	input  wire                                   out_valid,
	input  wire                                   out_ready,
	input  wire  signed [blr_pkg::COORD_BITS-1:0] pixel_x,
	input  wire  signed [blr_pkg::COORD_BITS-1:0] pixel_y,
	input  wire         [blr_pkg::ADDR_W-1:0]     pixel_address,
	input  wire         [blr_pkg::COLOR_W-1:0]    pixel_color,
	input  wire                                   inside_res,
	input  wire                                   last,
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire         [blr_pkg::PADDR_W-1:0]    paddr,
	input  wire         [blr_pkg::PDATA_W-1:0]    pwdata,
	input  wire                                   pready,
	output int                                    mismatches,
	output int                                    pixels_owed
);
	import blr_pkg::*;

	typedef struct packed {
		coord_t              x;
		coord_t              y;
		logic [ADDR_W-1:0]   addr;
		logic [COLOR_W-1:0]  color;
		logic                on_surface;
		logic                last;
	} pixel_t;

	logic [REG_W-1:0]   surf_w, surf_h;
	coord_t             cur_x, cur_y, goal_x, goal_y;
	delta_t             span_x, span_y;
	err_t               err;
	logic               x_neg, y_neg;
	logic [COLOR_W-1:0] held_color;
	logic               drawing;
	pixel_t             owed[$];
	pixel_t             px, want;
	int                 fail_total;

	task automatic load_line(input coord_t sx, sy, ex, ey, input logic [COLOR_W-1:0] c);
		cur_x = sx;
		cur_y = sy;
		goal_x = ex;
		goal_y = ey;
		span_x = (ex >= sx) ? delta_t'(ex) - delta_t'(sx) : delta_t'(sx) - delta_t'(ex);
		span_y = (ey >= sy) ? delta_t'(ey) - delta_t'(sy) : delta_t'(sy) - delta_t'(ey);
		x_neg = !(sx < ex);
		y_neg = !(sy < ey);
		err = (span_x > span_y) ? err_t'(span_x / 2) : err_t'(-(span_y / 2));
		held_color = c;
		drawing = 1'b1;
	endtask

	task automatic trace_pixel(output pixel_t p);
		int     e;
		longint lin;
		p.x = cur_x;
		p.y = cur_y;
		p.on_surface = cur_x >= 0 && cur_y >= 0 &&
			int'(cur_x) < int'(surf_w) && int'(cur_y) < int'(surf_h);
		lin = longint'(cur_y) * longint'(surf_w) + longint'(cur_x);
		p.addr = p.on_surface ? lin[ADDR_W-1:0] : '0;
		p.color = held_color;
		p.last = cur_x == goal_x && cur_y == goal_y;
		if (p.last) begin
			drawing = 1'b0;
		end else begin
			e = int'(err);
			if (e > -int'(span_x)) begin
				err = err_t'(int'(err) - int'(span_y));
				cur_x = coord_t'(int'(cur_x) + (x_neg ? -1 : 1));
			end
			if (e < int'(span_y)) begin
				err = err_t'(int'(err) + int'(span_x));
				cur_y = coord_t'(int'(cur_y) + (y_neg ? -1 : 1));
			end
		end
	endtask

	task automatic check_field(input string field, input logic [31:0] exp_v, act_v);
		if (exp_v !== act_v) begin
			if (fail_total < 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, field, exp_v, act_v);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surf_w = WIDTH_RESET;
			surf_h = HEIGHT_RESET;
			cur_x = '0;
			cur_y = '0;
			goal_x = '0;
			goal_y = '0;
			span_x = '0;
			span_y = '0;
			err = '0;
			x_neg = 1'b0;
			y_neg = 1'b0;
			held_color = '0;
			drawing = 1'b0;
			owed.delete();
			fail_total = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					{REG_WIDTH, 2'b00}:  surf_w = pwdata[REG_W-1:0];
					{REG_HEIGHT, 2'b00}: surf_h = pwdata[REG_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (command == CMD_START) begin
					load_line(start_x, start_y, end_x, end_y, line_color);
				end else if (drawing) begin
					trace_pixel(px);
					owed.push_back(px);
				end
			end
			if (out_valid && out_ready) begin
				if (owed.size() == 0) begin
					if (fail_total < 10)
						$display("%0t: pixel (%0d,%0d) emitted with none owed",
							$realtime, pixel_x, pixel_y);
					fail_total++;
				end else begin
					want = owed.pop_front();
					check_field("pixel_x", want.x, pixel_x);
					check_field("pixel_y", want.y, pixel_y);
					check_field("pixel_address", want.addr, pixel_address);
					check_field("pixel_color", want.color, pixel_color);
					check_field("inside_res", want.on_surface, inside_res);
					check_field("last", want.last, last);
				end
			end
		end
		mismatches <= fail_total;
		pixels_owed <= owed.size();
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives line start and step transactions and surface register writes into
// the rasterizer under random backpressure; the pixel checker judges results.
// ----------------------------------------------------------------------------

module testbench;
	import blr_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid, in_ready, command;
	coord_t                start_x, start_y, end_x, end_y;
	logic [COLOR_W-1:0]    line_color;
	logic                  out_valid, out_ready;
	coord_t                pixel_x, pixel_y;
	logic [ADDR_W-1:0]     pixel_address;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  inside_res, last;
	logic                  psel, penable, pwrite, pready;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata, prdata;
	int                    mismatches, pixels_owed;
	int                    send_idle_pct = 9;
	int                    recv_idle_pct = 9;
	int                    items_sent = 0;
	logic [REG_W-1:0]      surf_w = WIDTH_RESET;
	logic [REG_W-1:0]      surf_h = HEIGHT_RESET;

	always #5 clk = ~clk;

	bresenham_line_rasterizer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.line_color(line_color),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_address(pixel_address),
		.pixel_color(pixel_color), .inside_res(inside_res), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	blr_pixel_checker pixel_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.line_color(line_color),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_address(pixel_address),
		.pixel_color(pixel_color), .inside_res(inside_res), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatches(mismatches), .pixels_owed(pixels_owed)
	);

	always @(negedge clk) begin
		out_ready = $urandom_range(99) >= recv_idle_pct;
	end

	task automatic send(input cmd_t cmd, input coord_t sx, sy, ex, ey,
			input logic [COLOR_W-1:0] c);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			command = $urandom_range(1);
			{start_x, start_y, end_x, end_y} = {$urandom, $urandom};
			line_color = $urandom;
			@(negedge clk);
		end
		in_valid = 1'b1;
		command = cmd;
		start_x = sx;
		start_y = sy;
		end_x = ex;
		end_y = ey;
		line_color = c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic draw(input coord_t sx, sy, ex, ey, input logic [COLOR_W-1:0] c,
			input int steps);
		send(CMD_START, sx, sy, ex, ey, c);
		repeat (steps)
			send(CMD_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), $urandom);
	endtask

	task automatic random_line();
		int     span, ax, ay, n, r;
		coord_t sx, sy, ex, ey;
		r = $urandom_range(99);
		if (r < 8) begin
			sx = coord_t'($urandom);
			sy = coord_t'($urandom);
			ex = coord_t'($urandom);
			ey = coord_t'($urandom);
			draw(sx, sy, ex, ey, $urandom, $urandom_range(1, 6));
		end else begin
			span = ($urandom_range(9) == 0) ? 150 : 10;
			sx = coord_t'(int'($urandom_range(surf_w + 40)) - 20);
			sy = coord_t'(int'($urandom_range(surf_h + 40)) - 20);
			ex = coord_t'(int'(sx) + int'($urandom_range(2 * span)) - span);
			ey = coord_t'(int'(sy) + int'($urandom_range(2 * span)) - span);
			ax = int'(ex) - int'(sx);
			ay = int'(ey) - int'(sy);
			if (ax < 0) ax = -ax;
			if (ay < 0) ay = -ay;
			n = ((ax > ay) ? ax : ay) + 1;
			r = $urandom_range(99);
			if (r < 10)
				n = n + $urandom_range(1, 3);
			else if (r < 20)
				n = $urandom_range(n - 1);
			draw(sx, sy, ex, ey, $urandom, n);
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pixels_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int target);
		while (items_sent < target) begin
			if ($urandom_range(19) == 0)
				send(cmd_t'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom), $urandom);
			else
				random_line();
		end
		settle();
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = $urandom;
		pwdata[REG_W-1:0] = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx == REG_WIDTH)
			surf_w = value;
		else
			surf_h = value;
	endtask

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_START;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		line_color = '0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// step with no line, zero-length line, extreme diagonals, restart mid-line
		send(CMD_STEP, 16'sh1234, -16'sd7, 16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF);
		draw(16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0000, 2);
		draw(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF, 3);
		draw(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 32'h5AA5_C33C, 2);
		draw(-16'sd3, 16'sd2, 16'sd2, -16'sd1, 32'hA55A_3CC3, 6);
		draw(16'sd638, 16'sd478, 16'sd640, 16'sd482, 32'h8000_0001, 5);
		run_phase(300);

		write_reg(REG_WIDTH, '0);
		write_reg(REG_HEIGHT, '0);
		run_phase(400);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(REG_WIDTH, '1);
		write_reg(REG_HEIGHT, '1);
		run_phase(600);

		send_idle_pct = 9;
		recv_idle_pct = 9;
		write_reg(REG_WIDTH, REG_W'(1));
		write_reg(REG_HEIGHT, REG_W'(1));
		run_phase(700);

		write_reg(REG_WIDTH, REG_W'(4096));
		write_reg(REG_HEIGHT, REG_W'($urandom_range(1, 4096)));
		run_phase(950);

		if (mismatches == 0 && pixels_owed == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
